@@ hw/rtl/tmrca_pkg.sv @@
`timescale 1ns / 1ps

package tmrca_pkg;

  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CHAR_W = 8;
  localparam int CLR_W  = 3;
  localparam int RES_W  = 8;

  localparam logic [31:0] LCG_MUL   = 32'd1664525;
  localparam logic [31:0] LCG_ADD   = 32'd1013904223;
  localparam logic [31:0] LCG_RESET = 32'hDEADBEEF;

  localparam int GLYPH_COUNT = 48;
  localparam int WAKE_ODDS   = 30;
  localparam logic [3:0] PHASE_LAST = 4'd11;

  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
  localparam logic [2:0] ERASE_K = 3'd4;
  localparam logic [2:0] CELL_END = 3'd5;
  localparam logic [CLR_W-1:0] CLR_ERASE = 3'd0;

  localparam logic [31:0] RECIP_ROWS  = 32'((64'd1 << 32) / SCREEN_ROWS);
  localparam logic [31:0] RECIP_WAKE  = 32'((64'd1 << 32) / WAKE_ODDS);
  localparam logic [31:0] RECIP_GLYPH = 32'((64'd1 << 32) / GLYPH_COUNT);

  localparam logic [8*GLYPH_COUNT-1:0] GLYPHS =
    "01234567890ABCDEFGHIJKLMNOPQRSTUVWXYZ@#$%&*+-=<>";

  typedef enum logic [1:0] {
    OP_RESEED = 2'd0,
    OP_INIT   = 2'd1,
    OP_STEP   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DECIDE,
    ST_ADV,
    ST_MUL,
    ST_USE,
    ST_CELL,
    ST_EMIT,
    ST_ADVROW,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    DR_INIT_ROW,
    DR_INIT_SPD,
    DR_INIT_ACT,
    DR_WAKE,
    DR_GLYPH,
    DR_NEW_SPD,
    DR_RETIRE
  } draw_t;

  typedef struct packed {
    logic             act;
    logic [1:0]       spd;
    logic [ROW_W-1:0] row;
  } colent_t;

  typedef struct packed {
    logic  take;
    logic  load;
    logic  adv;
    logic  mul;
    logic  use_draw;
    logic  emit;
    logic  k_clr;
    logic  k_inc;
    logic  advrow;
    logic  finish;
    draw_t purp;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic col_ok;
    logic active;
    logic moves;
    logic k_done;
    logic k_erase;
    logic on_screen;
    logic wrap;
    logic out_free;
  } sts_t;

  function automatic logic [CHAR_W-1:0] glyph_char(input logic [5:0] idx);
    logic [CHAR_W-1:0] ch;
    ch = SPACE_CHAR;
    if (int'(idx) < GLYPH_COUNT) begin
      ch = GLYPHS[(GLYPH_COUNT - 1 - int'(idx)) * 8 +: 8];
    end
    return ch;
  endfunction

endpackage

@@ hw/rtl/tmrca_ctrl.sv @@
`timescale 1ns / 1ps

module tmrca_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tmrca_pkg::sts_t   sts,
  output tmrca_pkg::cmd_t   cmd
);

  tmrca_pkg::state_t state_r, state_nxt;
  tmrca_pkg::draw_t  purp_r, purp_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tmrca_pkg::ST_IDLE;
      purp_r  <= tmrca_pkg::DR_INIT_ROW;
    end else begin
      state_r <= state_nxt;
      purp_r  <= purp_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    purp_nxt  = purp_r;
    unique case (state_r)
      tmrca_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = tmrca_pkg::ST_FETCH;
        end
      end
      tmrca_pkg::ST_FETCH: begin
        if (!sts.col_ok) begin
          state_nxt = tmrca_pkg::ST_DONE;
        end else if (sts.op == tmrca_pkg::OP_INIT) begin
          purp_nxt  = tmrca_pkg::DR_INIT_ROW;
          state_nxt = tmrca_pkg::ST_ADV;
        end else if (sts.op == tmrca_pkg::OP_STEP) begin
          state_nxt = tmrca_pkg::ST_DECIDE;
        end else begin
          state_nxt = tmrca_pkg::ST_DONE;
        end
      end
      tmrca_pkg::ST_DECIDE: begin
        if (!sts.active) begin
          purp_nxt  = tmrca_pkg::DR_WAKE;
          state_nxt = tmrca_pkg::ST_ADV;
        end else if (sts.moves) begin
          state_nxt = tmrca_pkg::ST_CELL;
        end else begin
          state_nxt = tmrca_pkg::ST_DONE;
        end
      end
      tmrca_pkg::ST_ADV: begin
        state_nxt = tmrca_pkg::ST_MUL;
      end
      tmrca_pkg::ST_MUL: begin
        state_nxt = tmrca_pkg::ST_USE;
      end
      tmrca_pkg::ST_USE: begin
        unique case (purp_r)
          tmrca_pkg::DR_INIT_ROW: begin
            purp_nxt  = tmrca_pkg::DR_INIT_SPD;
            state_nxt = tmrca_pkg::ST_ADV;
          end
          tmrca_pkg::DR_INIT_SPD: begin
            purp_nxt  = tmrca_pkg::DR_INIT_ACT;
            state_nxt = tmrca_pkg::ST_ADV;
          end
          tmrca_pkg::DR_GLYPH: begin
            state_nxt = tmrca_pkg::ST_EMIT;
          end
          tmrca_pkg::DR_NEW_SPD: begin
            purp_nxt  = tmrca_pkg::DR_RETIRE;
            state_nxt = tmrca_pkg::ST_ADV;
          end
          default: begin
            state_nxt = tmrca_pkg::ST_DONE;
          end
        endcase
      end
      tmrca_pkg::ST_CELL: begin
        if (sts.k_done) begin
          state_nxt = tmrca_pkg::ST_ADVROW;
        end else if (sts.on_screen) begin
          if (sts.k_erase) begin
            state_nxt = tmrca_pkg::ST_EMIT;
          end else begin
            purp_nxt  = tmrca_pkg::DR_GLYPH;
            state_nxt = tmrca_pkg::ST_ADV;
          end
        end
      end
      tmrca_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          state_nxt = tmrca_pkg::ST_CELL;
        end
      end
      tmrca_pkg::ST_ADVROW: begin
        if (sts.wrap) begin
          purp_nxt  = tmrca_pkg::DR_NEW_SPD;
          state_nxt = tmrca_pkg::ST_ADV;
        end else begin
          state_nxt = tmrca_pkg::ST_DONE;
        end
      end
      tmrca_pkg::ST_DONE: begin
        state_nxt = tmrca_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = tmrca_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.purp = purp_r;
    in_stall = (state_r != tmrca_pkg::ST_IDLE);
    unique case (state_r)
      tmrca_pkg::ST_IDLE:   cmd.take     = in_valid;
      tmrca_pkg::ST_FETCH:  cmd.load     = 1'b1;
      tmrca_pkg::ST_DECIDE: cmd.k_clr    = 1'b1;
      tmrca_pkg::ST_ADV:    cmd.adv      = 1'b1;
      tmrca_pkg::ST_MUL:    cmd.mul      = 1'b1;
      tmrca_pkg::ST_USE:    cmd.use_draw = 1'b1;
      tmrca_pkg::ST_CELL: begin
        cmd.k_inc = !sts.k_done && !sts.on_screen;
      end
      tmrca_pkg::ST_EMIT: begin
        cmd.emit  = sts.out_free;
        cmd.k_inc = sts.out_free;
      end
      tmrca_pkg::ST_ADVROW: cmd.advrow   = 1'b1;
      tmrca_pkg::ST_DONE:   cmd.finish   = 1'b1;
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/tmrca_dpath.sv @@
`timescale 1ns / 1ps

module tmrca_dpath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tmrca_pkg::cmd_t                  cmd,
  output tmrca_pkg::sts_t                  sts,
  input  logic                             cfg_wr_en,
  input  logic [31:0]                      cfg_wr_data,
  input  logic [1:0]                       in_opcode,
  input  logic [tmrca_pkg::COL_W-1:0]      in_column,
  input  logic                             in_frame_end,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tmrca_pkg::COL_W-1:0]      out_cell_column,
  output logic [tmrca_pkg::ROW_W-1:0]      out_cell_row,
  output logic [tmrca_pkg::CHAR_W-1:0]     out_char_code,
  output logic [tmrca_pkg::CLR_W-1:0]      out_color_class,
  output logic                             out_last
);

  localparam logic [tmrca_pkg::COL_W-1:0] COLS =
    tmrca_pkg::COL_W'(tmrca_pkg::SCREEN_COLUMNS);

  tmrca_pkg::colent_t mem [tmrca_pkg::SCREEN_COLUMNS];
  tmrca_pkg::colent_t rdata_r;

  tmrca_pkg::op_t                 op_r;
  logic [tmrca_pkg::COL_W-1:0]    col_r;
  logic                           fend_r;
  logic [tmrca_pkg::ROW_W-1:0]    row_r;
  logic [1:0]                     spd_r;
  logic                           act_r;
  logic [2:0]                     k_r;
  logic [31:0]                    lcg_r, seed_r, prod_r;
  logic [3:0]                     phase_r;
  logic [tmrca_pkg::CHAR_W-1:0]   glyph_r;

  logic                           out_valid_r;
  logic [tmrca_pkg::COL_W-1:0]    ocol_r;
  logic [tmrca_pkg::ROW_W-1:0]    orow_r;
  logic [tmrca_pkg::CHAR_W-1:0]   ochar_r;
  logic [tmrca_pkg::CLR_W-1:0]    oclr_r;
  logic                           olast_r;

  logic                           col_ok, in_col_ok;
  logic [31:0]                    recip;
  logic [tmrca_pkg::RES_W-1:0]    dvsr, qd, res_raw, res;
  logic [63:0]                    prod_full;
  logic [15:0]                    qd_full;
  logic [tmrca_pkg::ROW_W:0]      row_ext, row_diff, row_inc;
  logic                           moves;
  logic                           out_free;

  assign col_ok    = (col_r < COLS);
  assign in_col_ok = (in_column < COLS);
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    recip = '0;
    dvsr  = '0;
    case (cmd.purp)
      tmrca_pkg::DR_INIT_ROW: begin
        recip = tmrca_pkg::RECIP_ROWS;
        dvsr  = tmrca_pkg::RES_W'(tmrca_pkg::SCREEN_ROWS);
      end
      tmrca_pkg::DR_WAKE: begin
        recip = tmrca_pkg::RECIP_WAKE;
        dvsr  = tmrca_pkg::RES_W'(tmrca_pkg::WAKE_ODDS);
      end
      tmrca_pkg::DR_GLYPH: begin
        recip = tmrca_pkg::RECIP_GLYPH;
        dvsr  = tmrca_pkg::RES_W'(tmrca_pkg::GLYPH_COUNT);
      end
      default: ;
    endcase
  end

  // quotient estimate is low by at most one, so one subtract corrects it
  assign prod_full = {32'd0, lcg_r} * {32'd0, recip};
  assign qd_full   = {8'd0, prod_r[7:0]} * {8'd0, dvsr};
  assign qd        = qd_full[tmrca_pkg::RES_W-1:0];
  assign res_raw   = lcg_r[tmrca_pkg::RES_W-1:0] - qd;
  assign res       = (res_raw >= dvsr) ? (res_raw - dvsr) : res_raw;

  always_comb begin
    case (spd_r)
      2'd0:    moves = 1'b1;
      2'd1:    moves = !phase_r[0];
      2'd2:    moves = (phase_r == 4'd0) || (phase_r == 4'd3) ||
                       (phase_r == 4'd6) || (phase_r == 4'd9);
      default: moves = (phase_r[1:0] == 2'd0);
    endcase
  end

  assign row_ext  = {1'b0, row_r};
  assign row_diff = row_ext - {{(tmrca_pkg::ROW_W-2){1'b0}}, k_r};
  assign row_inc  = row_ext + 1'b1;

  always_comb begin
    sts.op        = op_r;
    sts.col_ok    = col_ok;
    sts.active    = act_r;
    sts.moves     = moves;
    sts.k_done    = (k_r == tmrca_pkg::CELL_END);
    sts.k_erase   = (k_r == tmrca_pkg::ERASE_K);
    sts.on_screen = (row_ext >= {{(tmrca_pkg::ROW_W-2){1'b0}}, k_r}) &&
                    (row_diff < (tmrca_pkg::ROW_W+1)'(tmrca_pkg::SCREEN_ROWS));
    sts.wrap      = (row_inc > (tmrca_pkg::ROW_W+1)'(tmrca_pkg::SCREEN_ROWS + 4));
    sts.out_free  = out_free;
  end

  always_ff @(posedge clk) begin
    if (cmd.take && in_col_ok) begin
      rdata_r <= mem[in_column];
    end
    if (cmd.finish && col_ok &&
        (op_r == tmrca_pkg::OP_INIT || op_r == tmrca_pkg::OP_STEP)) begin
      mem[col_r] <= '{act: act_r, spd: spd_r, row: row_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r   <= tmrca_pkg::op_t'(in_opcode);
      col_r  <= in_column;
      fend_r <= in_frame_end;
    end
    if (cmd.load) begin
      row_r <= rdata_r.row;
      spd_r <= rdata_r.spd;
      act_r <= rdata_r.act;
    end
    if (cmd.k_clr) begin
      k_r <= '0;
    end else if (cmd.k_inc) begin
      k_r <= k_r + 3'd1;
    end
    if (cmd.mul) begin
      prod_r <= prod_full[63:32];
    end
    if (cmd.advrow) begin
      row_r <= sts.wrap ? '0 : row_inc[tmrca_pkg::ROW_W-1:0];
    end
    if (cmd.use_draw) begin
      case (cmd.purp)
        tmrca_pkg::DR_INIT_ROW: row_r <= res[tmrca_pkg::ROW_W-1:0];
        tmrca_pkg::DR_INIT_SPD: spd_r <= lcg_r[1:0];
        tmrca_pkg::DR_INIT_ACT: act_r <= !lcg_r[0];
        tmrca_pkg::DR_WAKE: begin
          if (res == '0) begin
            act_r <= 1'b1;
          end
        end
        tmrca_pkg::DR_GLYPH:    glyph_r <= tmrca_pkg::glyph_char(res[5:0]);
        tmrca_pkg::DR_NEW_SPD:  spd_r <= lcg_r[1:0];
        tmrca_pkg::DR_RETIRE: begin
          if (lcg_r[1:0] == 2'd0) begin
            act_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r  <= tmrca_pkg::LCG_RESET;
      lcg_r   <= tmrca_pkg::LCG_RESET;
      phase_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
      if (cmd.adv) begin
        lcg_r <= lcg_r * tmrca_pkg::LCG_MUL + tmrca_pkg::LCG_ADD;
      end
      if (cmd.finish) begin
        if (op_r == tmrca_pkg::OP_RESEED) begin
          lcg_r   <= seed_r;
          phase_r <= '0;
        end else if (op_r == tmrca_pkg::OP_STEP && fend_r) begin
          phase_r <= (phase_r == tmrca_pkg::PHASE_LAST) ? 4'd0 : phase_r + 4'd1;
        end
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      ocol_r  <= col_r;
      orow_r  <= row_diff[tmrca_pkg::ROW_W-1:0];
      olast_r <= (k_r == tmrca_pkg::ERASE_K) ||
                 (row_ext == {{(tmrca_pkg::ROW_W-2){1'b0}}, k_r});
      if (k_r == tmrca_pkg::ERASE_K) begin
        ochar_r <= tmrca_pkg::SPACE_CHAR;
        oclr_r  <= tmrca_pkg::CLR_ERASE;
      end else begin
        ochar_r <= glyph_r;
        oclr_r  <= k_r + 3'd1;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cell_column = ocol_r;
  assign out_cell_row    = orow_r;
  assign out_char_code   = ochar_r;
  assign out_color_class = oclr_r;
  assign out_last        = olast_r;

endmodule

@@ hw/rtl/text_mode_rain_column_animator.sv @@
`timescale 1ns / 1ps

// Rain column animator for an 80 by 25 text screen. One command word at a
// time: reseed (loads the generator from cfg_wr_data's register, clears the
// frame phase), initialize column, or step column; a step of a moving column
// yields up to five cell words, the final one flagged by out_last. Each
// generator draw runs an LCG multiply, a reciprocal multiply for the
// remainder and a correction in turn; each trail slot gets a bookkeeping
// step, and a written cell waits while out_stall holds the output word.
module text_mode_rain_column_animator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [31:0]                      cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_opcode,
  input  logic [tmrca_pkg::COL_W-1:0]      in_column,
  input  logic                             in_frame_end,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tmrca_pkg::COL_W-1:0]      out_cell_column,
  output logic [tmrca_pkg::ROW_W-1:0]      out_cell_row,
  output logic [tmrca_pkg::CHAR_W-1:0]     out_char_code,
  output logic [tmrca_pkg::CLR_W-1:0]      out_color_class,
  output logic                             out_last
);

  tmrca_pkg::cmd_t cmd;
  tmrca_pkg::sts_t sts;

  tmrca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tmrca_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_opcode       (in_opcode),
    .in_column       (in_column),
    .in_frame_end    (in_frame_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_cell_column (out_cell_column),
    .out_cell_row    (out_cell_row),
    .out_char_code   (out_char_code),
    .out_color_class (out_color_class),
    .out_last        (out_last)
  );

endmodule
